@@ src/scsv_pkg.sv @@
// Shared widths, constants and types of the segment closest-vector pipeline.
package scsv_pkg;

    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int N_COORDS        = 12;
    localparam int IN_W            = COORD_W * N_COORDS;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int DOT_W           = PROD_W + 2;
    localparam int HALF_W          = DOT_W / 2;
    localparam int MAG_W           = 4 * HALF_W;
    localparam int WIDE_W          = MAG_W + 1;
    localparam int PARAM_W         = 17;
    localparam int QUOT_W          = PARAM_W + 1;
    localparam int GAP_SHIFT       = PARAM_W - 1;
    localparam int ACC_W           = DIFF_W + PARAM_W + 2;
    localparam int OUT_RAW_W       = 3 * COORD_W + 2 * PARAM_W;
    localparam int OUT_W           = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int SMALL_DEN       = 100000000;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        t_diff [2:0] u;
        t_diff [2:0] v;
        t_diff [2:0] w;
    } t_uvw;

    typedef struct packed {
        t_dot a;
        t_dot b;
        t_dot c;
        t_dot d;
        t_dot e;
    } t_dots;

    typedef struct packed {
        t_dots dots;
        t_wide det;
        t_wide s_num;
        t_wide t_num;
    } t_det_res;

    typedef struct packed {
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             zero;
    } t_ratio_job;

    typedef struct packed {
        logic [PARAM_W-1:0] sc;
        logic [PARAM_W-1:0] tc;
    } t_params;

endpackage

@@ src/scsv_dot.sv @@
// Difference vectors and the five dot products, three register stages.
module scsv_dot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [scsv_pkg::IN_W-1:0]  i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output scsv_pkg::t_dots            o_dots,
    output scsv_pkg::t_uvw             o_uvw
);
    localparam int STAGES = 3;
    localparam int CW     = scsv_pkg::COORD_W;

    typedef logic signed [scsv_pkg::PROD_W-1:0] t_prod;

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   go;

    scsv_pkg::t_uvw  n_uvw;
    scsv_pkg::t_uvw  r_uvw [STAGES];
    t_prod           r_prod [5][3];
    scsv_pkg::t_dots n_dots;
    scsv_pkg::t_dots r_dots;

    assign go[STAGES] = i_ready;
    for (genvar gk = 0; gk < STAGES; gk++) begin : g_go
        assign go[gk] = !r_v[gk] || go[gk+1];
    end
    assign o_ready = go[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            if (go[1]) r_v[1] <= r_v[0];
            if (go[2]) r_v[2] <= r_v[1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_uvw.u[k] = scsv_pkg::t_diff'($signed(i_data[k*CW +: CW]))
                       - scsv_pkg::t_diff'($signed(i_data[(3+k)*CW +: CW]));
            n_uvw.v[k] = scsv_pkg::t_diff'($signed(i_data[(6+k)*CW +: CW]))
                       - scsv_pkg::t_diff'($signed(i_data[(9+k)*CW +: CW]));
            n_uvw.w[k] = scsv_pkg::t_diff'($signed(i_data[(3+k)*CW +: CW]))
                       - scsv_pkg::t_diff'($signed(i_data[(9+k)*CW +: CW]));
        end
    end

    always_comb begin
        n_dots.a = scsv_pkg::t_dot'(r_prod[0][0]) + scsv_pkg::t_dot'(r_prod[0][1])
                 + scsv_pkg::t_dot'(r_prod[0][2]);
        n_dots.b = scsv_pkg::t_dot'(r_prod[1][0]) + scsv_pkg::t_dot'(r_prod[1][1])
                 + scsv_pkg::t_dot'(r_prod[1][2]);
        n_dots.c = scsv_pkg::t_dot'(r_prod[2][0]) + scsv_pkg::t_dot'(r_prod[2][1])
                 + scsv_pkg::t_dot'(r_prod[2][2]);
        n_dots.d = scsv_pkg::t_dot'(r_prod[3][0]) + scsv_pkg::t_dot'(r_prod[3][1])
                 + scsv_pkg::t_dot'(r_prod[3][2]);
        n_dots.e = scsv_pkg::t_dot'(r_prod[4][0]) + scsv_pkg::t_dot'(r_prod[4][1])
                 + scsv_pkg::t_dot'(r_prod[4][2]);
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) r_uvw[0] <= n_uvw;
        if (go[1]) begin
            r_uvw[1] <= r_uvw[0];
            for (int k = 0; k < 3; k++) begin
                r_prod[0][k] <= $signed(r_uvw[0].u[k]) * $signed(r_uvw[0].u[k]);
                r_prod[1][k] <= $signed(r_uvw[0].u[k]) * $signed(r_uvw[0].v[k]);
                r_prod[2][k] <= $signed(r_uvw[0].v[k]) * $signed(r_uvw[0].v[k]);
                r_prod[3][k] <= $signed(r_uvw[0].u[k]) * $signed(r_uvw[0].w[k]);
                r_prod[4][k] <= $signed(r_uvw[0].v[k]) * $signed(r_uvw[0].w[k]);
            end
        end
        if (go[2]) begin
            r_uvw[2] <= r_uvw[1];
            r_dots   <= n_dots;
        end
    end

    assign o_dots = r_dots;
    assign o_uvw  = r_uvw[STAGES-1];

endmodule

@@ src/scsv_det.sv @@
// Determinant and the two raw numerators from split partial products, four stages.
module scsv_det (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  scsv_pkg::t_dots      i_dots,
    input  scsv_pkg::t_uvw       i_uvw,
    output logic                 o_valid,
    input  logic                 i_ready,
    output scsv_pkg::t_det_res   o_res,
    output scsv_pkg::t_uvw       o_uvw
);
    localparam int STAGES = 4;
    localparam int DW     = scsv_pkg::DOT_W;
    localparam int HW     = scsv_pkg::HALF_W;
    localparam int MW     = scsv_pkg::MAG_W;

    // Operand pairs: a*c, b*b, b*e, c*d, a*e, b*d.
    localparam int OPX [6] = '{0, 1, 1, 2, 0, 1};
    localparam int OPY [6] = '{2, 1, 4, 3, 4, 3};

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   go;

    scsv_pkg::t_dot    dv [5];
    logic [DW-1:0]     r_mag [5];
    logic              r_sgn [5];
    logic [2*HW-1:0]   r_pp [6][4];
    logic              r_psgn [6];
    scsv_pkg::t_wide   n_prod [6];
    scsv_pkg::t_wide   r_prod [6];
    scsv_pkg::t_dots   r_dots [STAGES-1];
    scsv_pkg::t_uvw    r_uvw [STAGES];
    scsv_pkg::t_det_res r_res;
    logic [MW-1:0]     mag [6];

    assign go[STAGES] = i_ready;
    for (genvar gk = 0; gk < STAGES; gk++) begin : g_go
        assign go[gk] = !r_v[gk] || go[gk+1];
    end
    assign o_ready = go[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (go[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign dv[0] = i_dots.a;
    assign dv[1] = i_dots.b;
    assign dv[2] = i_dots.c;
    assign dv[3] = i_dots.d;
    assign dv[4] = i_dots.e;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            mag[j]    = (MW'(r_pp[j][3]) << (2 * HW))
                      + ((MW'(r_pp[j][1]) + MW'(r_pp[j][2])) << HW)
                      + MW'(r_pp[j][0]);
            n_prod[j] = r_psgn[j] ? -$signed({1'b0, mag[j]}) : $signed({1'b0, mag[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_dots[0] <= i_dots;
            r_uvw[0]  <= i_uvw;
            for (int k = 0; k < 5; k++) begin
                r_sgn[k] <= dv[k][DW-1];
                r_mag[k] <= dv[k][DW-1] ? DW'(-dv[k]) : DW'(dv[k]);
            end
        end
        if (go[1]) begin
            r_dots[1] <= r_dots[0];
            r_uvw[1]  <= r_uvw[0];
            for (int j = 0; j < 6; j++) begin
                r_psgn[j]  <= r_sgn[OPX[j]] ^ r_sgn[OPY[j]];
                r_pp[j][0] <= r_mag[OPX[j]][HW-1:0]  * r_mag[OPY[j]][HW-1:0];
                r_pp[j][1] <= r_mag[OPX[j]][HW-1:0]  * r_mag[OPY[j]][DW-1:HW];
                r_pp[j][2] <= r_mag[OPX[j]][DW-1:HW] * r_mag[OPY[j]][HW-1:0];
                r_pp[j][3] <= r_mag[OPX[j]][DW-1:HW] * r_mag[OPY[j]][DW-1:HW];
            end
        end
        if (go[2]) begin
            r_dots[2] <= r_dots[1];
            r_uvw[2]  <= r_uvw[1];
            for (int j = 0; j < 6; j++) r_prod[j] <= n_prod[j];
        end
        if (go[3]) begin
            r_uvw[3]    <= r_uvw[2];
            r_res.dots  <= r_dots[2];
            r_res.det   <= r_prod[0] - r_prod[1];
            r_res.s_num <= r_prod[2] - r_prod[3];
            r_res.t_num <= r_prod[4] - r_prod[5];
        end
    end

    assign o_res = r_res;
    assign o_uvw = r_uvw[STAGES-1];

endmodule

@@ src/scsv_clamp.sv @@
// Parallel-case choice, end clamping and tiny tests that set up both divisions.
module scsv_clamp #(
    parameter int COORD_FRAC_BITS = scsv_pkg::COORD_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  scsv_pkg::t_det_res        i_res,
    input  scsv_pkg::t_uvw            i_uvw,
    output logic                      o_valid,
    input  logic                      i_ready,
    output scsv_pkg::t_ratio_job [1:0] o_jobs,
    output scsv_pkg::t_uvw            o_uvw
);
    localparam int STAGES = 3;
    localparam int MW     = scsv_pkg::MAG_W;

    // Tiny thresholds for quantities of degree four, two and zero in the coordinates.
    localparam logic [MW-1:0] TINY4 =
        (MW'(1) << (4 * COORD_FRAC_BITS)) / MW'(scsv_pkg::SMALL_DEN);
    localparam logic [MW-1:0] TINY2 =
        (MW'(1) << (2 * COORD_FRAC_BITS)) / MW'(scsv_pkg::SMALL_DEN);
    localparam logic [MW-1:0] TINY0 = MW'(1) / MW'(scsv_pkg::SMALL_DEN);

    typedef enum logic [1:0] {DEG0, DEG2, DEG4} t_deg;

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   go;

    scsv_pkg::t_wide a_w, b_w, c_w, d_w, e_w;
    scsv_pkg::t_wide n0_sn, n0_sd, n0_tn, n0_td, n0_m1, n0_m2;
    t_deg            n0_sdeg, n0_tdeg;
    scsv_pkg::t_wide r0_sn, r0_sd, r0_tn, r0_td, r0_m1, r0_m2, r0_a;
    t_deg            r0_sdeg, r0_tdeg;
    logic            r0_m1neg, r0_m1gt, r0_m2neg, r0_m2gt;

    scsv_pkg::t_wide n1_sn, n1_sd, n1_tn, r1_sn, r1_sd, r1_tn, r1_td;
    t_deg            n1_sdeg, r1_sdeg, r1_tdeg;
    logic            tneg, tgt, m_neg, m_gt;
    scsv_pkg::t_wide m_sel;

    scsv_pkg::t_ratio_job [1:0] r_jobs;
    scsv_pkg::t_ratio_job [1:0] n_jobs;
    scsv_pkg::t_uvw             r_uvw [STAGES];

    function automatic logic [MW-1:0] tiny_of(input t_deg deg);
        case (deg)
            DEG0:    tiny_of = TINY0;
            DEG2:    tiny_of = TINY2;
            DEG4:    tiny_of = TINY4;
            default: tiny_of = TINY4;
        endcase
    endfunction

    assign go[STAGES] = i_ready;
    for (genvar gk = 0; gk < STAGES; gk++) begin : g_go
        assign go[gk] = !r_v[gk] || go[gk+1];
    end
    assign o_ready = go[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            if (go[1]) r_v[1] <= r_v[0];
            if (go[2]) r_v[2] <= r_v[1];
        end
    end

    assign a_w = scsv_pkg::t_wide'(i_res.dots.a);
    assign b_w = scsv_pkg::t_wide'(i_res.dots.b);
    assign c_w = scsv_pkg::t_wide'(i_res.dots.c);
    assign d_w = scsv_pkg::t_wide'(i_res.dots.d);
    assign e_w = scsv_pkg::t_wide'(i_res.dots.e);
    assign n0_m1 = -d_w;
    assign n0_m2 = b_w - d_w;

    // First choice: near-parallel segments, otherwise clamp sN to [0, D].
    always_comb begin
        n0_sn   = i_res.s_num;
        n0_sd   = i_res.det;
        n0_sdeg = DEG4;
        n0_tn   = i_res.t_num;
        n0_td   = i_res.det;
        n0_tdeg = DEG4;
        if (i_res.det < $signed({1'b0, TINY4})) begin
            n0_sn   = '0;
            n0_sd   = scsv_pkg::t_wide'(1);
            n0_sdeg = DEG0;
            n0_tn   = e_w;
            n0_td   = c_w;
            n0_tdeg = DEG2;
        end else if (i_res.s_num[scsv_pkg::WIDE_W-1]) begin
            n0_sn   = '0;
            n0_tn   = e_w;
            n0_td   = c_w;
            n0_tdeg = DEG2;
        end else if (i_res.s_num > i_res.det) begin
            n0_sn   = i_res.det;
            n0_tn   = e_w + b_w;
            n0_td   = c_w;
            n0_tdeg = DEG2;
        end
    end

    // Second choice: clamp tN to [0, tD] and recompute sN against that end.
    assign tneg  = r0_tn[scsv_pkg::WIDE_W-1];
    assign tgt   = r0_tn > r0_td;
    assign m_sel = tneg ? r0_m1 : r0_m2;
    assign m_neg = tneg ? r0_m1neg : r0_m2neg;
    assign m_gt  = tneg ? r0_m1gt : r0_m2gt;

    always_comb begin
        n1_sn   = r0_sn;
        n1_sd   = r0_sd;
        n1_sdeg = r0_sdeg;
        n1_tn   = r0_tn;
        if (tneg) n1_tn = '0;
        else if (tgt) n1_tn = r0_td;
        if (tneg || tgt) begin
            if (m_neg) begin
                n1_sn = '0;
            end else if (m_gt) begin
                n1_sn = r0_sd;
            end else begin
                n1_sn   = m_sel;
                n1_sd   = r0_a;
                n1_sdeg = DEG2;
            end
        end
    end

    always_comb begin
        n_jobs[0].num  = MW'(r1_sn);
        n_jobs[0].den  = MW'(r1_sd);
        n_jobs[0].zero = (r1_sd == '0) || (MW'(r1_sn) < tiny_of(r1_sdeg));
        n_jobs[1].num  = MW'(r1_tn);
        n_jobs[1].den  = MW'(r1_td);
        n_jobs[1].zero = (r1_td == '0) || (MW'(r1_tn) < tiny_of(r1_tdeg));
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_uvw[0] <= i_uvw;
            r0_sn    <= n0_sn;
            r0_sd    <= n0_sd;
            r0_sdeg  <= n0_sdeg;
            r0_tn    <= n0_tn;
            r0_td    <= n0_td;
            r0_tdeg  <= n0_tdeg;
            r0_a     <= a_w;
            r0_m1    <= n0_m1;
            r0_m2    <= n0_m2;
            r0_m1neg <= n0_m1[scsv_pkg::WIDE_W-1];
            r0_m2neg <= n0_m2[scsv_pkg::WIDE_W-1];
            r0_m1gt  <= n0_m1 > a_w;
            r0_m2gt  <= n0_m2 > a_w;
        end
        if (go[1]) begin
            r_uvw[1] <= r_uvw[0];
            r1_sn    <= n1_sn;
            r1_sd    <= n1_sd;
            r1_sdeg  <= n1_sdeg;
            r1_tn    <= n1_tn;
            r1_td    <= r0_td;
            r1_tdeg  <= r0_tdeg;
        end
        if (go[2]) begin
            r_uvw[2] <= r_uvw[1];
            r_jobs   <= n_jobs;
        end
    end

    assign o_jobs = r_jobs;
    assign o_uvw  = r_uvw[STAGES-1];

endmodule

@@ src/scsv_div.sv @@
// Two-lane pipelined restoring divider: one quotient bit per stage, rounded at the exit.
module scsv_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  scsv_pkg::t_ratio_job [1:0] i_jobs,
    input  scsv_pkg::t_uvw             i_uvw,
    output logic                       o_valid,
    input  logic                       i_ready,
    output scsv_pkg::t_params          o_params,
    output scsv_pkg::t_uvw             o_uvw
);
    localparam int STAGES = scsv_pkg::QUOT_W;
    localparam int MW     = scsv_pkg::MAG_W;
    localparam int QW     = scsv_pkg::QUOT_W;
    localparam int PW     = scsv_pkg::PARAM_W;

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   go;

    logic [MW-1:0]   r_rem  [STAGES][2];
    logic [MW-1:0]   r_den  [STAGES][2];
    logic [QW-1:0]   r_q    [STAGES][2];
    logic            r_zero [STAGES][2];
    scsv_pkg::t_uvw  r_uvw  [STAGES];
    logic [MW:0]     part   [STAGES][2];
    logic [MW:0]     res    [STAGES][2];
    logic [QW:0]     q_inc  [2];
    logic [PW-1:0]   param  [2];

    // Returns the quotient bit above the new remainder.
    function automatic logic [MW:0] div_step(input logic [MW:0] part_in,
                                             input logic [MW-1:0] den);
        logic [MW:0] diff;
        diff = part_in - {1'b0, den};
        div_step = diff[MW] ? {1'b0, part_in[MW-1:0]} : {1'b1, diff[MW-1:0]};
    endfunction

    assign go[STAGES] = i_ready;
    for (genvar gk = 0; gk < STAGES; gk++) begin : g_go
        assign go[gk] = !r_v[gk] || go[gk+1];
    end
    assign o_ready = go[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (go[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // The numerator never exceeds the denominator, so the first bit is the top one.
            part[0][l] = {1'b0, i_jobs[l].num};
            res[0][l]  = div_step(part[0][l], i_jobs[l].den);
            for (int s = 1; s < STAGES; s++) begin
                part[s][l] = {r_rem[s-1][l], 1'b0};
                res[s][l]  = div_step(part[s][l], r_den[s-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_uvw[0] <= i_uvw;
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l]  <= res[0][l][MW-1:0];
                r_den[0][l]  <= i_jobs[l].den;
                r_q[0][l]    <= QW'(res[0][l][MW]);
                r_zero[0][l] <= i_jobs[l].zero;
            end
        end
        for (int s = 1; s < STAGES; s++) begin
            if (go[s]) begin
                r_uvw[s] <= r_uvw[s-1];
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l]  <= res[s][l][MW-1:0];
                    r_den[s][l]  <= r_den[s-1][l];
                    r_q[s][l]    <= {r_q[s-1][l][QW-2:0], res[s][l][MW]};
                    r_zero[s][l] <= r_zero[s-1][l];
                end
            end
        end
    end

    // Round half up: the quotient carries one extra fraction bit.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q_inc[l] = {1'b0, r_q[STAGES-1][l]} + (QW+1)'(1);
            param[l] = r_zero[STAGES-1][l] ? '0 : q_inc[l][PW:1];
        end
    end

    assign o_params.sc = param[0];
    assign o_params.tc = param[1];
    assign o_uvw       = r_uvw[STAGES-1];

endmodule

@@ src/scsv_gap.sv @@
// Gap vector w + sc*u - tc*v with rounding and saturation, two stages.
module scsv_gap (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  scsv_pkg::t_params                       i_params,
    input  scsv_pkg::t_uvw                          i_uvw,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [2:0][scsv_pkg::COORD_W-1:0] o_gap,
    output scsv_pkg::t_params                       o_params
);
    localparam int STAGES = 2;
    localparam int AW     = scsv_pkg::ACC_W;
    localparam int CW     = scsv_pkg::COORD_W;
    localparam int SH     = scsv_pkg::GAP_SHIFT;
    localparam int QW     = AW - SH;

    typedef logic signed [AW-1:0] t_acc;

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   go;

    t_acc              r_sw [3];
    t_acc              r_su [3];
    t_acc              r_tv [3];
    t_acc              acc  [3];
    logic [QW-1:0]     quo  [3];
    logic [2:0][CW-1:0] n_gap;
    logic [2:0][CW-1:0] r_gap;
    scsv_pkg::t_params r_par [STAGES];

    assign go[STAGES] = i_ready;
    for (genvar gk = 0; gk < STAGES; gk++) begin : g_go
        assign go[gk] = !r_v[gk] || go[gk+1];
    end
    assign o_ready = go[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            if (go[1]) r_v[1] <= r_v[0];
        end
    end

    // An arithmetic shift floors; the added half makes it round half up.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = r_sw[k] + r_su[k] - r_tv[k] + (t_acc'(1) <<< (SH - 1));
            quo[k] = acc[k][AW-1:SH];
            if ((&quo[k][QW-1:CW-1]) || !(|quo[k][QW-1:CW-1])) begin
                n_gap[k] = quo[k][CW-1:0];
            end else begin
                n_gap[k] = quo[k][QW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_par[0] <= i_params;
            for (int k = 0; k < 3; k++) begin
                r_sw[k] <= t_acc'($signed(i_uvw.w[k])) <<< SH;
                r_su[k] <= $signed({1'b0, i_params.sc}) * $signed(i_uvw.u[k]);
                r_tv[k] <= $signed({1'b0, i_params.tc}) * $signed(i_uvw.v[k]);
            end
        end
        if (go[1]) begin
            r_par[1] <= r_par[0];
            r_gap    <= n_gap;
        end
    end

    assign o_gap    = r_gap;
    assign o_params = r_par[STAGES-1];

endmodule

@@ src/segment_segment_closest_vector.sv @@
// Top level of the segment-to-segment closest-vector pipeline.
//
//  channel   direction  width  contents
//  s_axis    in         384    two end points of segment A, then of segment B
//  m_axis    out        136    gap vector B to A, param_a, param_b
//
// One pair of segments is taken per cycle while the pipeline is not stalled; a
// result passes the dot-product, determinant and clamp stages, then the 18-stage
// restoring divider and the gap stages.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A full stage holds while its successor is full and stalled, so bubbles close up
// and a waiting result does not stop new beats entering empty stages.
module segment_segment_closest_vector #(
    parameter int COORD_FRAC_BITS = scsv_pkg::COORD_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_end1_x, a_end1_y, a_end1_z, a_end2_x, a_end2_y, a_end2_z,
    // b_end1_x, b_end1_y, b_end1_z, b_end2_x, b_end2_y, b_end2_z
    input  logic [scsv_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // gap_x, gap_y, gap_z, param_a, param_b, zero fill
    output logic [scsv_pkg::OUT_W-1:0] m_axis_tdata
);
    logic                       dot_valid, dot_ready;
    scsv_pkg::t_dots            dot_dots;
    scsv_pkg::t_uvw             dot_uvw;
    logic                       det_valid, det_ready;
    scsv_pkg::t_det_res         det_res;
    scsv_pkg::t_uvw             det_uvw;
    logic                       clp_valid, clp_ready;
    scsv_pkg::t_ratio_job [1:0] clp_jobs;
    scsv_pkg::t_uvw             clp_uvw;
    logic                       div_valid, div_ready;
    scsv_pkg::t_params          div_params;
    scsv_pkg::t_uvw             div_uvw;
    logic signed [2:0][scsv_pkg::COORD_W-1:0] gap;
    scsv_pkg::t_params          gap_params;

    scsv_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (dot_valid),
        .i_ready (dot_ready),
        .o_dots  (dot_dots),
        .o_uvw   (dot_uvw)
    );

    scsv_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dot_valid),
        .o_ready (dot_ready),
        .i_dots  (dot_dots),
        .i_uvw   (dot_uvw),
        .o_valid (det_valid),
        .i_ready (det_ready),
        .o_res   (det_res),
        .o_uvw   (det_uvw)
    );

    scsv_clamp #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (det_valid),
        .o_ready (det_ready),
        .i_res   (det_res),
        .i_uvw   (det_uvw),
        .o_valid (clp_valid),
        .i_ready (clp_ready),
        .o_jobs  (clp_jobs),
        .o_uvw   (clp_uvw)
    );

    scsv_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (clp_valid),
        .o_ready  (clp_ready),
        .i_jobs   (clp_jobs),
        .i_uvw    (clp_uvw),
        .o_valid  (div_valid),
        .i_ready  (div_ready),
        .o_params (div_params),
        .o_uvw    (div_uvw)
    );

    scsv_gap u_gap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .o_ready  (div_ready),
        .i_params (div_params),
        .i_uvw    (div_uvw),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_gap    (gap),
        .o_params (gap_params)
    );

    assign m_axis_tdata = {{(scsv_pkg::OUT_W - scsv_pkg::OUT_RAW_W){1'b0}},
                           gap_params.tc, gap_params.sc, gap[2], gap[1], gap[0]};

endmodule
